FILE: sv/pkst_pkg.sv
// Shared types, constants and time-compare helpers for the power key shutdown timer.
`timescale 1ns / 1ps

package pkst_pkg;

  // Widths of times, registers and item fields
  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 20;
  localparam int HOLD_W     = 20;
  localparam int TPS_W      = 12;
  localparam int SECS_W     = 8;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int ARM_LEN_W  = 20;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Register reset values
  localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = 20'd3500;
  localparam logic [HOLD_W-1:0]  HOLD_LIMIT_RST    = 20'd500;
  localparam logic [TPS_W-1:0]   TPS_RST           = 12'd100;

  // Accepted range of a shutdown request in seconds
  localparam logic [SECS_W-1:0] SECS_MIN = 8'd1;
  localparam logic [SECS_W-1:0] SECS_MAX = 8'd120;

  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_KEY     = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_REQUEST = 2'd2,
    FUNC_SUSPEND = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RELEASE_DELAY = 2'd0,
    REG_HOLD_LIMIT    = 2'd1,
    REG_TPS           = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DELAY_W-1:0] release_delay_ticks;
    logic [HOLD_W-1:0]  hold_limit_ticks;
    logic [TPS_W-1:0]   ticks_per_second;
  } cfg_t;

  typedef struct packed {
    func_t              func;
    logic               key_level;
    logic [SECS_W-1:0]  request_seconds;
  } item_t;

  typedef struct packed {
    logic wake_press;
    logic key_report_valid;
    logic key_down;
    logic power_off;
    logic request_rejected;
  } result_t;

  // a at or after b, on wrapping time
  function automatic logic at_or_after(input time_t a, input time_t b);
    time_t d;
    d = a - b;
    return !d[TIME_W-1];
  endfunction

  // a strictly after b, on wrapping time
  function automatic logic strictly_after(input time_t a, input time_t b);
    time_t d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

FILE: sv/pkst_cfg.sv
// Configuration register file: release delay, hold limit and ticks per second.
`timescale 1ns / 1ps

module pkst_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pkst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pkst_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pkst_pkg::cfg_t                   cfg
);
  import pkst_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Take a write beat whenever out of reset
  assign cfg_ready = rst_n;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_RELEASE_DELAY: cfg_nxt.release_delay_ticks = cfg_data[DELAY_W-1:0];
        REG_HOLD_LIMIT:    cfg_nxt.hold_limit_ticks    = cfg_data[HOLD_W-1:0];
        REG_TPS:           cfg_nxt.ticks_per_second    = cfg_data[TPS_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_delay_ticks <= RELEASE_DELAY_RST;
      cfg_r.hold_limit_ticks    <= HOLD_LIMIT_RST;
      cfg_r.ticks_per_second    <= TPS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/pkst_core.sv
// Key, countdown and power-off state with the per-item update logic.
`timescale 1ns / 1ps

module pkst_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  pkst_pkg::item_t   item,
  input  pkst_pkg::cfg_t    cfg,
  output pkst_pkg::result_t res,
  output logic              powered_off
);
  import pkst_pkg::*;

  time_t now_r,         now_nxt;
  logic  key_held_r,    key_held_nxt;
  time_t press_start_r, press_start_nxt;
  logic  suspended_r,   suspended_nxt;
  logic  armed_r,       armed_nxt;
  time_t next_check_r,  next_check_nxt;
  time_t deadline_r,    deadline_nxt;
  logic  pwr_off_r,     pwr_off_nxt;

  logic [ARM_LEN_W-1:0] req_len;
  logic [ARM_LEN_W-1:0] arm_len;
  time_t                now_inc;
  time_t                hold_end;
  time_t                tps_ext;

  // Countdown length: seconds times ticks per second, or the release delay
  assign req_len  = ARM_LEN_W'(item.request_seconds) * ARM_LEN_W'(cfg.ticks_per_second);
  assign arm_len  = (item.func == FUNC_REQUEST) ? req_len
                                                : ARM_LEN_W'(cfg.release_delay_ticks);
  assign now_inc  = now_r + time_t'(1);
  assign hold_end = press_start_r + TIME_W'(cfg.hold_limit_ticks);
  assign tps_ext  = TIME_W'(cfg.ticks_per_second);

  // Apply one item to the state and form its result
  always_comb begin
    now_nxt         = now_r;
    key_held_nxt    = key_held_r;
    press_start_nxt = press_start_r;
    suspended_nxt   = suspended_r;
    armed_nxt       = armed_r;
    next_check_nxt  = next_check_r;
    deadline_nxt    = deadline_r;
    pwr_off_nxt     = pwr_off_r;
    res             = '0;

    unique case (item.func)
      FUNC_KEY: begin
        res.key_report_valid = 1'b1;
        if (item.key_level) begin
          // release: wake report after suspend, arm if it ends a press
          if (suspended_r) begin
            res.wake_press = 1'b1;
            suspended_nxt  = 1'b0;
          end
          if (key_held_r) begin
            deadline_nxt   = now_r + TIME_W'(arm_len);
            next_check_nxt = now_r + tps_ext;
            armed_nxt      = 1'b1;
          end
          key_held_nxt = 1'b0;
        end else begin
          // press: keep the start time of the first press
          res.key_down  = 1'b1;
          suspended_nxt = 1'b0;
          if (!key_held_r) begin
            key_held_nxt    = 1'b1;
            press_start_nxt = now_r;
          end
        end
      end
      FUNC_TICK: begin
        now_nxt = now_inc;
        if (armed_r && at_or_after(now_inc, next_check_r)) begin
          if (key_held_r && strictly_after(now_inc, hold_end)) begin
            pwr_off_nxt = 1'b1;
          end
          if (strictly_after(deadline_r, now_inc)) begin
            next_check_nxt = now_inc + tps_ext;
          end else begin
            pwr_off_nxt = 1'b1;
            armed_nxt   = 1'b0;
          end
        end
      end
      FUNC_REQUEST: begin
        if ((item.request_seconds < SECS_MIN) || (item.request_seconds > SECS_MAX)) begin
          res.request_rejected = 1'b1;
        end else begin
          deadline_nxt   = now_r + TIME_W'(arm_len);
          next_check_nxt = now_r + tps_ext;
          armed_nxt      = 1'b1;
        end
      end
      FUNC_SUSPEND: begin
        suspended_nxt = 1'b1;
      end
      default: begin
        suspended_nxt = suspended_r;
      end
    endcase

    res.power_off = pwr_off_nxt;
  end

  // Commit the update only when an item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      key_held_r    <= 1'b0;
      press_start_r <= '0;
      suspended_r   <= 1'b0;
      armed_r       <= 1'b0;
      next_check_r  <= '0;
      deadline_r    <= '0;
      pwr_off_r     <= 1'b0;
    end else if (step) begin
      now_r         <= now_nxt;
      key_held_r    <= key_held_nxt;
      press_start_r <= press_start_nxt;
      suspended_r   <= suspended_nxt;
      armed_r       <= armed_nxt;
      next_check_r  <= next_check_nxt;
      deadline_r    <= deadline_nxt;
      pwr_off_r     <= pwr_off_nxt;
    end
  end

  assign powered_off = pwr_off_r;

endmodule

FILE: sv/power_key_shutdown_timer.sv
// Top level of the power key shutdown timer: input register, core, result register.
`timescale 1ns / 1ps
//
// Power key controller with a delayed, sticky power-off countdown.
// Input channel (in_*): one beat per event; in_tuser carries the kind
// (key level, tick, shutdown request, suspend), in_tdata the key level
// and the requested seconds. Result channel (out_*): exactly one beat per
// input beat, in order, with key report, wake press, reject and the
// power-off level after that event. Config channel (cfg_*): register
// index and data; write only while no events are in flight.
// The input register and the result register each hold one beat.
// Throughput is one beat per cycle while the receiver does not stall;
// the state update is a single pass of adds and compares plus one 8x12
// multiply, all between those two registers.
// Reset (rst_n low, synchronous) clears all timer and key state, loads
// the register defaults and holds in_tready and cfg_ready low.
// When the receiver stalls, the result is held; an empty input register
// still takes one beat, and in_tready drops while it is full.
//
module power_key_shutdown_timer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pkst_pkg::FUNC_W-1:0]      in_tuser,  // [1:0] func
  input  logic [pkst_pkg::IN_DATA_W-1:0]   in_tdata,  // [0] key_level, [8:1] request_seconds
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] wake_press, [1] key_report_valid, [2] key_down, [3] power_off,
  // [4] request_rejected
  output logic [pkst_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pkst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pkst_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pkst_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_valid_r, in_valid_nxt;
  result_t core_res;
  result_t out_res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;
  logic    step;
  logic    powered_off;

  pkst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move a beat on when the result register is empty or being drained
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = rst_n && (!in_valid_r || advance);

  always_comb begin
    in_valid_nxt  = in_tready ? in_tvalid : in_valid_r;
    out_valid_nxt = advance ? in_valid_r : out_valid_r;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.func            <= func_t'(in_tuser);
      in_item_r.key_level       <= in_tdata[0];
      in_item_r.request_seconds <= in_tdata[SECS_W:1];
    end
  end

  pkst_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_item_r),
    .cfg         (cfg),
    .res         (core_res),
    .powered_off (powered_off)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.request_rejected,
                       out_res_r.power_off,
                       out_res_r.key_down,
                       out_res_r.key_report_valid,
                       out_res_r.wake_press};

  // Power off never clears once set
  a_power_off_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(powered_off)) |-> powered_off)
    else $error("power-off state dropped");

  // A stepped item leaves a result whose power_off matches the new state
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (out_valid_r && (out_res_r.power_off == powered_off)))
    else $error("result power_off differs from state");

  // Input stalls only when both registers are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule
